// ===== hdl/dissolved_oxygen_compensation_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dissolved oxygen compensation block
// Shared property forms, all clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DISSOLVED_OXYGEN_COMPENSATION_MACROS_SVH
`define DISSOLVED_OXYGEN_COMPENSATION_MACROS_SVH

// pre implies post in the same cycle
`define DOC_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// pre implies post in the next cycle
`define DOC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// pre implies post a fixed number of cycles later
`define DOC_ASSERT_LATER(name, pre, n, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> ##(n) (post)) \
    else $error(msg);

`endif

// ===== hdl/doc_pkg.sv =====
// ----------------------------------------------------------------------------
// doc_pkg
// Widths, constants, shared types and the reference oxygen table.
// ----------------------------------------------------------------------------
`default_nettype none

package doc_pkg;

  localparam int ADC_BITS = 12;

  localparam int AdcW     = ADC_BITS;
  localparam int TempW    = 6;
  localparam int MvW      = 12;
  localparam int PtsW     = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int ScaleW   = 26;   // holds 3300 * largest table entry
  localparam int QuotW    = ScaleW;
  localparam int ReadingW = 26;
  localparam int SatW     = 16;
  localparam int MagW     = 18;   // |(T - t2) * (v1 - v2)| stays below 2^18
  localparam int DenW     = 6;
  localparam int ProdW    = AdcW + ScaleW;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int FullScaleMv = 3300;
  localparam int MvPerDegree = 35;
  localparam logic [TempW-1:0] TableLast = TempW'(40);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxMode   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxPoints = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgIdxV1     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgIdxT1     = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgIdxV2     = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgIdxT2     = CfgIdxW'(5);

  // Calibration point counts
  localparam logic [PtsW-1:0] CfgPointsOne = PtsW'(1);
  localparam logic [PtsW-1:0] CfgPointsTwo = PtsW'(2);

  typedef enum logic [1:0] {
    KIND_MV,
    KIND_ONE,
    KIND_TWO,
    KIND_ERR
  } item_kind_e;

  typedef struct packed {
    logic            mode;
    logic [PtsW-1:0] points;
    logic [MvW-1:0]  v1;
    logic [TempW-1:0] t1;
    logic [MvW-1:0]  v2;
    logic [TempW-1:0] t2;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    mode:   1'b0,
    points: CfgPointsOne,
    v1:     '0,
    t1:     TempW'(25),
    v2:     '0,
    t2:     TempW'(15)
  };

  // Classified request handed from the front end to the back end
  typedef struct packed {
    logic [AdcW-1:0]   adc;
    logic [ScaleW-1:0] scale;
    logic [SatW-1:0]   divisor;
    logic              err;
  } item_t;

  // Reference oxygen (ug/L) at each whole degree, premultiplied by full scale mV
  function automatic logic [ScaleW-1:0] ref_scale(input logic [TempW-1:0] idx);
    logic [ScaleW-1:0] scale;
    case (idx)
      6'd0:    scale = ScaleW'(14460 * FullScaleMv);
      6'd1:    scale = ScaleW'(14220 * FullScaleMv);
      6'd2:    scale = ScaleW'(13820 * FullScaleMv);
      6'd3:    scale = ScaleW'(13440 * FullScaleMv);
      6'd4:    scale = ScaleW'(13090 * FullScaleMv);
      6'd5:    scale = ScaleW'(12740 * FullScaleMv);
      6'd6:    scale = ScaleW'(12420 * FullScaleMv);
      6'd7:    scale = ScaleW'(12110 * FullScaleMv);
      6'd8:    scale = ScaleW'(11810 * FullScaleMv);
      6'd9:    scale = ScaleW'(11530 * FullScaleMv);
      6'd10:   scale = ScaleW'(11260 * FullScaleMv);
      6'd11:   scale = ScaleW'(11010 * FullScaleMv);
      6'd12:   scale = ScaleW'(10770 * FullScaleMv);
      6'd13:   scale = ScaleW'(10530 * FullScaleMv);
      6'd14:   scale = ScaleW'(10300 * FullScaleMv);
      6'd15:   scale = ScaleW'(10080 * FullScaleMv);
      6'd16:   scale = ScaleW'(9860 * FullScaleMv);
      6'd17:   scale = ScaleW'(9660 * FullScaleMv);
      6'd18:   scale = ScaleW'(9460 * FullScaleMv);
      6'd19:   scale = ScaleW'(9270 * FullScaleMv);
      6'd20:   scale = ScaleW'(9080 * FullScaleMv);
      6'd21:   scale = ScaleW'(8900 * FullScaleMv);
      6'd22:   scale = ScaleW'(8730 * FullScaleMv);
      6'd23:   scale = ScaleW'(8570 * FullScaleMv);
      6'd24:   scale = ScaleW'(8410 * FullScaleMv);
      6'd25:   scale = ScaleW'(8250 * FullScaleMv);
      6'd26:   scale = ScaleW'(8110 * FullScaleMv);
      6'd27:   scale = ScaleW'(7960 * FullScaleMv);
      6'd28:   scale = ScaleW'(7820 * FullScaleMv);
      6'd29:   scale = ScaleW'(7690 * FullScaleMv);
      6'd30:   scale = ScaleW'(7560 * FullScaleMv);
      6'd31:   scale = ScaleW'(7430 * FullScaleMv);
      6'd32:   scale = ScaleW'(7300 * FullScaleMv);
      6'd33:   scale = ScaleW'(7180 * FullScaleMv);
      6'd34:   scale = ScaleW'(7070 * FullScaleMv);
      6'd35:   scale = ScaleW'(6950 * FullScaleMv);
      6'd36:   scale = ScaleW'(6840 * FullScaleMv);
      6'd37:   scale = ScaleW'(6730 * FullScaleMv);
      6'd38:   scale = ScaleW'(6630 * FullScaleMv);
      6'd39:   scale = ScaleW'(6530 * FullScaleMv);
      default: scale = ScaleW'(6410 * FullScaleMv);
    endcase
    return scale;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/doc_front.sv =====
// ----------------------------------------------------------------------------
// doc_front
// Classifies each request, finds the table scale and the saturation voltage.
// The two-point slope goes through a one-bit-per-stage unsigned divider on magnitudes; the sign is applied after.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dissolved_oxygen_compensation_macros.svh"

module doc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  doc_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  input  logic [doc_pkg::AdcW-1:0]    adc_i,
  input  logic [doc_pkg::TempW-1:0]   temp_i,
  output logic                        out_valid_o,
  output doc_pkg::item_t              out_item_o
);

  typedef struct packed {
    logic [doc_pkg::AdcW-1:0]   adc;
    doc_pkg::item_kind_e        kind;
    logic [doc_pkg::ScaleW-1:0] scale;
    logic [doc_pkg::SatW-1:0]   one_sat;
    logic                       neg;
    logic [doc_pkg::DenW-1:0]   den;
    logic [doc_pkg::DenW-1:0]   rem;
    logic [doc_pkg::MagW-1:0]   num;
  } fdiv_t;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  function automatic fdiv_t fdiv_step(input fdiv_t cur);
    logic [doc_pkg::DenW:0] trial;
    logic [doc_pkg::DenW:0] diff;
    logic                   take;
    fdiv_t                  nxt;
    trial = {cur.rem, cur.num[doc_pkg::MagW-1]};
    diff  = trial - {1'b0, cur.den};
    take  = (trial >= {1'b0, cur.den});
    nxt      = cur;
    nxt.rem  = take ? diff[doc_pkg::DenW-1:0] : trial[doc_pkg::DenW-1:0];
    nxt.num  = {cur.num[doc_pkg::MagW-2:0], take};
    return nxt;
  endfunction

  logic                      s1_valid_q;
  logic [doc_pkg::AdcW-1:0]  s1_adc_q;
  logic [doc_pkg::TempW-1:0] s1_temp_q;

  logic signed [doc_pkg::DenW:0]            dt;
  logic signed [doc_pkg::DenW:0]            den_s;
  logic signed [doc_pkg::MvW:0]             dv;
  logic signed [doc_pkg::DenW+doc_pkg::MvW+1:0] prod_s;
  logic [doc_pkg::DenW+doc_pkg::MvW+1:0]    prod_abs;
  logic [doc_pkg::DenW:0]                   den_abs;
  logic [doc_pkg::SatW-1:0]                 one_sat;
  logic [doc_pkg::TempW-1:0]                tbl_idx;
  doc_pkg::item_kind_e                      kind;

  fdiv_t                 fst_d [doc_pkg::MagW+1];
  fdiv_t                 fst_q [doc_pkg::MagW+1];
  logic [doc_pkg::MagW:0] fv_q;

  fdiv_t                    last;
  logic [doc_pkg::SatW-1:0] quot;
  logic [doc_pkg::SatW-1:0] sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fv_q       <= '0;
    end else begin
      s1_valid_q <= in_valid_i;
      fv_q       <= {fv_q[doc_pkg::MagW-1:0], s1_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_adc_q  <= adc_i;
      s1_temp_q <= temp_i;
    end
    for (int k = 0; k <= doc_pkg::MagW; k++) begin
      fst_q[k] <= fst_d[k];
    end
  end

  // Classify and set up the slope division
  always_comb begin
    dt       = $signed({1'b0, s1_temp_q}) - $signed({1'b0, cfg_i.t2});
    den_s    = $signed({1'b0, cfg_i.t1}) - $signed({1'b0, cfg_i.t2});
    dv       = $signed({1'b0, cfg_i.v1}) - $signed({1'b0, cfg_i.v2});
    prod_s   = dt * dv;
    prod_abs = prod_s[doc_pkg::DenW+doc_pkg::MvW+1] ? $unsigned(-prod_s) : $unsigned(prod_s);
    den_abs  = den_s[doc_pkg::DenW] ? $unsigned(-den_s) : $unsigned(den_s);
    // wraps at 16 bits on purpose
    one_sat  = doc_pkg::SatW'(cfg_i.v1)
             + doc_pkg::SatW'(s1_temp_q) * doc_pkg::SatW'(doc_pkg::MvPerDegree)
             - doc_pkg::SatW'(cfg_i.t1) * doc_pkg::SatW'(doc_pkg::MvPerDegree);
    tbl_idx  = (s1_temp_q > doc_pkg::TableLast) ? doc_pkg::TableLast : s1_temp_q;

    if (cfg_i.mode) begin
      kind = doc_pkg::KIND_MV;
    end else begin
      case (cfg_i.points)
        doc_pkg::CfgPointsOne: kind = doc_pkg::KIND_ONE;
        doc_pkg::CfgPointsTwo: kind = (den_s == '0) ? doc_pkg::KIND_ERR : doc_pkg::KIND_TWO;
        default:               kind = doc_pkg::KIND_ERR;
      endcase
    end

    fst_d[0].adc     = s1_adc_q;
    fst_d[0].kind    = kind;
    fst_d[0].scale   = cfg_i.mode ? doc_pkg::ScaleW'(doc_pkg::FullScaleMv)
                                  : doc_pkg::ref_scale(tbl_idx);
    fst_d[0].one_sat = one_sat;
    fst_d[0].neg     = prod_s[doc_pkg::DenW+doc_pkg::MvW+1] ^ den_s[doc_pkg::DenW];
    fst_d[0].den     = den_abs[doc_pkg::DenW-1:0];
    fst_d[0].rem     = '0;
    fst_d[0].num     = prod_abs[doc_pkg::MagW-1:0];

    for (int k = 0; k < doc_pkg::MagW; k++) begin
      fst_d[k+1] = fdiv_step(fst_q[k]);
    end
  end

  // Finish the saturation voltage and flag bad calibrations
  always_comb begin
    last = fst_q[doc_pkg::MagW];
    quot = last.num[doc_pkg::SatW-1:0];
    case (last.kind)
      doc_pkg::KIND_MV:  sat = doc_pkg::SatW'(1);
      doc_pkg::KIND_ONE: sat = last.one_sat;
      doc_pkg::KIND_TWO: sat = last.neg ? doc_pkg::SatW'(cfg_i.v2) - quot
                                        : doc_pkg::SatW'(cfg_i.v2) + quot;
      default:           sat = '0;
    endcase
    out_item_o.adc     = last.adc;
    out_item_o.scale   = last.scale;
    out_item_o.divisor = sat;
    out_item_o.err     = (last.kind == doc_pkg::KIND_ERR) || (sat == '0);
    out_valid_o        = fv_q[doc_pkg::MagW];
  end

  `DOC_ASSERT_NOW(a_two_point_span, fv_q[0] && (fst_q[0].kind == doc_pkg::KIND_TWO), fst_q[0].den != '0, "two-point request with zero temperature span")
  `DOC_ASSERT_NOW(a_mv_never_err, out_valid_o && (last.kind == doc_pkg::KIND_MV), !out_item_o.err, "millivolt request flagged as error")

endmodule

`default_nettype wire

// ===== hdl/doc_queue.sv =====
// ----------------------------------------------------------------------------
// doc_queue
// Short FIFO between front end and back end; drains whenever not empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dissolved_oxygen_compensation_macros.svh"

module doc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  doc_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  output doc_pkg::item_t pop_item_o,
  output logic           full_o
);

  doc_pkg::item_t               mem_q [doc_pkg::QueueDepth];
  logic [doc_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [doc_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [doc_pkg::QueueCntW-1:0] count_q, count_d;
  logic                          pop;

  always_comb begin
    pop         = (count_q != '0);
    pop_valid_o = pop;
    pop_item_o  = mem_q[rd_ptr_q];
    full_o      = (count_q == doc_pkg::QueueCntW'(doc_pkg::QueueDepth));

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == doc_pkg::QueuePtrW'(doc_pkg::QueueDepth - 1))
               ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == doc_pkg::QueuePtrW'(doc_pkg::QueueDepth - 1))
               ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + doc_pkg::QueueCntW'(push_i) - doc_pkg::QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `DOC_ASSERT_NOW(a_no_overflow, push_i, count_q != doc_pkg::QueueCntW'(doc_pkg::QueueDepth), "push into a full queue")
  `DOC_ASSERT_NEXT(a_push_drains, push_i, pop_valid_o, "pushed request not offered to the back end")

endmodule

`default_nettype wire

// ===== hdl/doc_back.sv =====
// ----------------------------------------------------------------------------
// doc_back
// Scales the sample by the table value, then divides by the saturation
// voltage in a one-bit-per-stage unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dissolved_oxygen_compensation_macros.svh"

module doc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  doc_pkg::item_t               in_item_i,
  output logic                         res_valid_o,
  output logic [doc_pkg::ReadingW-1:0] reading_o,
  output logic                         math_error_o
);

  typedef struct packed {
    logic [doc_pkg::QuotW-1:0] num;
    logic [doc_pkg::SatW-1:0]  rem;
    logic [doc_pkg::SatW-1:0]  div;
    logic                      err;
  } bdiv_t;

  function automatic bdiv_t bdiv_step(input bdiv_t cur);
    logic [doc_pkg::SatW:0] trial;
    logic [doc_pkg::SatW:0] diff;
    logic                   take;
    bdiv_t                  nxt;
    trial = {cur.rem, cur.num[doc_pkg::QuotW-1]};
    diff  = trial - {1'b0, cur.div};
    take  = (trial >= {1'b0, cur.div});
    nxt     = cur;
    nxt.rem = take ? diff[doc_pkg::SatW-1:0] : trial[doc_pkg::SatW-1:0];
    nxt.num = {cur.num[doc_pkg::QuotW-2:0], take};
    return nxt;
  endfunction

  logic [doc_pkg::ProdW-1:0] prod;
  bdiv_t                     bst_d [doc_pkg::QuotW+1];
  bdiv_t                     bst_q [doc_pkg::QuotW+1];
  logic [doc_pkg::QuotW:0]   bv_q;

  logic                         res_valid_q;
  logic [doc_pkg::ReadingW-1:0] reading_q, reading_d;
  logic                         err_q;

  always_comb begin
    // drop the converter full-scale bits right after the multiply
    prod           = doc_pkg::ProdW'(in_item_i.adc) * doc_pkg::ProdW'(in_item_i.scale);
    bst_d[0].num   = prod[doc_pkg::AdcW +: doc_pkg::QuotW];
    bst_d[0].rem   = '0;
    bst_d[0].div   = in_item_i.divisor;
    bst_d[0].err   = in_item_i.err;
    for (int k = 0; k < doc_pkg::QuotW; k++) begin
      bst_d[k+1] = bdiv_step(bst_q[k]);
    end
    reading_d = bst_q[doc_pkg::QuotW].err ? '0
              : doc_pkg::ReadingW'(bst_q[doc_pkg::QuotW].num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      bv_q        <= {bv_q[doc_pkg::QuotW-1:0], in_valid_i};
      res_valid_q <= bv_q[doc_pkg::QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= doc_pkg::QuotW; k++) begin
      bst_q[k] <= bst_d[k];
    end
    reading_q <= reading_d;
    err_q     <= bst_q[doc_pkg::QuotW].err;
  end

  assign res_valid_o  = res_valid_q;
  assign reading_o    = reading_q;
  assign math_error_o = err_q;

  `DOC_ASSERT_LATER(a_back_latency, in_valid_i, doc_pkg::QuotW + 2, res_valid_o, "back end lost a request")

endmodule

`default_nettype wire

// ===== hdl/dissolved_oxygen_compensation.sv =====
// ----------------------------------------------------------------------------
// dissolved_oxygen_compensation
// Temperature-compensated dissolved oxygen reading from a probe sample.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive adc_sample_i and water_temp_i with start high; the request
//   is taken at a rising edge where start is high and busy is low.
//   Result: result_valid_o is high for exactly one cycle with reading_o and
//   math_error_o; the receiver must take it then, there is no back-pressure.
//   Path: a taken request passes the input register, the setup stage and the
//   18-stage slope divider in the front end, the queue, then the multiply
//   stage, the 26-stage quotient divider and the result register in the back
//   end.
//   Throughput: one request per cycle; busy only rises if the queue between
//   the front and back end fills, which the always-draining back end prevents.
//   Configuration: write cfg_data_i to register cfg_index_i with cfg_we_i high,
//   only while no request is in flight. Indexes beyond the list are ignored.
//   Reset: drops every request in flight and restores register defaults
//   (oxygen mode, one calibration point, 0 mV at 25 C, 0 mV at 15 C).
// ----------------------------------------------------------------------------
`default_nettype none

module dissolved_oxygen_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [doc_pkg::AdcW-1:0]     adc_sample_i,
  input  logic [doc_pkg::TempW-1:0]    water_temp_i,
  input  logic                         cfg_we_i,
  input  logic [doc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [doc_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         result_valid_o,
  output logic [doc_pkg::ReadingW-1:0] reading_o,
  output logic                         math_error_o
);

  doc_pkg::cfg_t  cfg_q, cfg_d;
  logic           accept;
  logic           front_valid;
  doc_pkg::item_t front_item;
  logic           back_valid;
  doc_pkg::item_t back_item;
  logic           queue_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        doc_pkg::CfgIdxMode:   cfg_d.mode   = cfg_data_i[0];
        doc_pkg::CfgIdxPoints: cfg_d.points = cfg_data_i[doc_pkg::PtsW-1:0];
        doc_pkg::CfgIdxV1:     cfg_d.v1     = cfg_data_i[doc_pkg::MvW-1:0];
        doc_pkg::CfgIdxT1:     cfg_d.t1     = cfg_data_i[doc_pkg::TempW-1:0];
        doc_pkg::CfgIdxV2:     cfg_d.v2     = cfg_data_i[doc_pkg::MvW-1:0];
        doc_pkg::CfgIdxT2:     cfg_d.t2     = cfg_data_i[doc_pkg::TempW-1:0];
        default:               cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= doc_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign busy   = queue_full;
  assign accept = start && !busy;

  doc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (accept),
    .adc_i       (adc_sample_i),
    .temp_i      (water_temp_i),
    .out_valid_o (front_valid),
    .out_item_o  (front_item)
  );

  doc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_item_i (front_item),
    .pop_valid_o (back_valid),
    .pop_item_o  (back_item),
    .full_o      (queue_full)
  );

  doc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (back_valid),
    .in_item_i    (back_item),
    .res_valid_o  (result_valid_o),
    .reading_o    (reading_o),
    .math_error_o (math_error_o)
  );

endmodule

`default_nettype wire

// ===== sim/dissolved_oxygen_compensation_test.sv =====
// ----------------------------------------------------------------------------
// dissolved_oxygen_compensation_test
// Drives probe samples through the oxygen compensation block under changing
// calibration settings, predicts every reading in a scoreboard and compares
// each result strobe field by field, in order.
// ----------------------------------------------------------------------------
module dissolved_oxygen_compensation_test;
  import doc_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 8;
  localparam int TimeoutCycles = 100000;
  localparam int SettleCycles  = 60;
  localparam int ItemsPerPhase = 425;
  localparam int ReportLimit   = 60;

  // Indexes past the register list and point counts the block rejects
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = CfgIdxW'(7);
  localparam logic [PtsW-1:0]    CfgPointsNone = PtsW'(0);
  localparam logic [PtsW-1:0]    CfgPointsBad  = PtsW'(3);

  // Reference oxygen in ug/L per whole degree C, 0 to 40
  localparam int unsigned OxygenRefUgl [41] = '{
    14460, 14220, 13820, 13440, 13090, 12740, 12420, 12110, 11810, 11530,
    11260, 11010, 10770, 10530, 10300, 10080, 9860, 9660, 9460, 9270,
    9080, 8900, 8730, 8570, 8410, 8250, 8110, 7960, 7820, 7690,
    7560, 7430, 7300, 7180, 7070, 6950, 6840, 6730, 6630, 6530,
    6410
  };

  typedef struct packed {
    logic [ReadingW-1:0] reading;
    logic                math_error;
  } oxygen_result_t;

  class oxygen_scoreboard;
    cfg_t           regs;
    oxygen_result_t expected_q[$];
    int unsigned    fail_count;

    function new();
      regs.mode   = 1'b0;
      regs.points = CfgPointsOne;
      regs.v1     = '0;
      regs.t1     = TempW'(25);
      regs.v2     = '0;
      regs.t2     = TempW'(15);
      fail_count  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgIdxMode:   regs.mode   = data[0];
        CfgIdxPoints: regs.points = data[PtsW-1:0];
        CfgIdxV1:     regs.v1     = data[MvW-1:0];
        CfgIdxT1:     regs.t1     = data[TempW-1:0];
        CfgIdxV2:     regs.v2     = data[MvW-1:0];
        CfgIdxT2:     regs.t2     = data[TempW-1:0];
        default: ;
      endcase
    endfunction

    function oxygen_result_t predict_reading(logic [AdcW-1:0] adc, logic [TempW-1:0] temp);
      oxygen_result_t res;
      logic [SatW-1:0] sat;
      longint          slope_num;
      longint          slope_den;
      int unsigned     ref_idx;
      res = '0;
      sat = '0;
      if (regs.mode) begin
        res.reading = ReadingW'((longint'(adc) * FullScaleMv) >> AdcW);
        return res;
      end
      if (regs.points == CfgPointsOne) begin
        sat = SatW'(longint'(regs.v1) + MvPerDegree * longint'(temp)
                    - MvPerDegree * longint'(regs.t1));
      end else if (regs.points == CfgPointsTwo && regs.t1 != regs.t2) begin
        // signed quotient, truncated toward zero
        slope_num = (longint'(temp) - longint'(regs.t2)) * (longint'(regs.v1) - longint'(regs.v2));
        slope_den = longint'(regs.t1) - longint'(regs.t2);
        sat = SatW'(slope_num / slope_den + longint'(regs.v2));
      end
      if (sat == '0) begin
        res.math_error = 1'b1;
        return res;
      end
      ref_idx = (temp > 40) ? 40 : int'(temp);
      res.reading = ReadingW'((longint'(adc) * FullScaleMv * longint'(OxygenRefUgl[ref_idx]))
                              / ((longint'(1) << AdcW) * longint'(sat)));
      return res;
    endfunction

    function void note_request(logic [AdcW-1:0] adc, logic [TempW-1:0] temp);
      expected_q.push_back(predict_reading(adc, temp));
    endfunction

    function void report_failure();
      fail_count++;
    endfunction

    function void check_result(logic [ReadingW-1:0] reading, logic math_error);
      oxygen_result_t exp_res;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $error("unexpected result: reading %0d math_error %0b", reading, math_error);
        return;
      end
      exp_res = expected_q.pop_front();
      if (reading !== exp_res.reading) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $error("reading: expected %0d, got %0d", exp_res.reading, reading);
      end
      if (math_error !== exp_res.math_error) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $error("math_error: expected %0b, got %0b", exp_res.math_error, math_error);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [AdcW-1:0]     adc_sample_i;
  logic [TempW-1:0]    water_temp_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                result_valid_o;
  logic [ReadingW-1:0] reading_o;
  logic                math_error_o;

  oxygen_scoreboard sb;
  int unsigned      idle_pct;

  dissolved_oxygen_compensation dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .adc_sample_i   (adc_sample_i),
    .water_temp_i   (water_temp_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .reading_o      (reading_o),
    .math_error_o   (math_error_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Sample handshakes with the values that held before the edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) sb.note_request(adc_sample_i, water_temp_i);
      if (result_valid_o === 1'b1) sb.check_result(reading_o, math_error_o);
    end
  end

  task automatic send_request(logic [AdcW-1:0] adc, logic [TempW-1:0] temp);
    cfg_we_i <= 1'b0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start        <= 1'b1;
    adc_sample_i <= adc;
    water_temp_i <= temp;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic send_random();
    logic [AdcW-1:0]  adc;
    logic [TempW-1:0] temp;
    adc = AdcW'($urandom_range(4095));
    if ($urandom_range(9) == 0) adc = $urandom_range(1) ? {AdcW{1'b1}} : '0;
    temp = ($urandom_range(99) < 85) ? TempW'($urandom_range(40)) : TempW'($urandom_range(63));
    send_request(adc, temp);
  endtask

  // Hold off until every request has come back; the request just taken is
  // put on the books before the scoreboard is asked what is pending
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [CfgDataW-1:0] mode, logic [CfgDataW-1:0] points,
                           logic [CfgDataW-1:0] v1, logic [CfgDataW-1:0] t1,
                           logic [CfgDataW-1:0] v2, logic [CfgDataW-1:0] t2);
    wait_idle();
    write_reg(CfgIdxMode, mode);
    write_reg(CfgIdxPoints, points);
    write_reg(CfgIdxV1, v1);
    write_reg(CfgIdxT1, t1);
    write_reg(CfgIdxV2, v2);
    write_reg(CfgIdxT2, t2);
  endtask

  task automatic random_calibration();
    logic [PtsW-1:0]     pts;
    logic [CfgDataW-1:0] v1, v2, t1, t2;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 40)      pts = CfgPointsOne;
    else if (pick < 88) pts = CfgPointsTwo;
    else                pts = $urandom_range(1) ? CfgPointsNone : CfgPointsBad;
    v1 = ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(4095)) : CfgDataW'($urandom_range(3300));
    v2 = ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(4095)) : CfgDataW'($urandom_range(3300));
    t1 = ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(4095)) : CfgDataW'($urandom_range(40));
    t2 = ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(4095)) : CfgDataW'($urandom_range(40));
    // upper data bits are random junk the block must mask off
    configure({(CfgDataW-1)'($urandom_range(2047)), 1'b0} | CfgDataW'($urandom_range(99) < 15),
              {(CfgDataW-PtsW)'($urandom_range(1023)), pts}, v1, t1, v2, t2);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? CfgIdxSpareLo : CfgIdxSpareHi, CfgDataW'($urandom_range(4095)));
  endtask

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned batch;
    sb           = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    adc_sample_i = '0;
    water_temp_i = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    idle_pct     = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one point at 0 mV / 25 C, so 25 C gives zero saturation
    send_request(AdcW'(4095), TempW'(25));
    send_request(AdcW'(4095), TempW'(0));
    send_request(AdcW'(0), TempW'(0));
    send_request(AdcW'(4095), TempW'(40));
    send_request(AdcW'(1), TempW'(41));
    send_request(AdcW'(4095), TempW'(63));

    // Millivolt mode, written with junk above the mode bit
    configure(CfgDataW'(12'hFFF), CfgDataW'(CfgPointsOne), '0, CfgDataW'(25), '0, CfgDataW'(15));
    send_request(AdcW'(0), TempW'(0));
    send_request(AdcW'(4095), TempW'(63));
    send_request(AdcW'(2048), TempW'(20));

    // Two points at the field extremes; masked data clears mode and t1
    configure(CfgDataW'(12'hFFE), CfgDataW'(12'hFFE), CfgDataW'(4095), CfgDataW'(12'hFC0),
              '0, CfgDataW'(12'hFFF));
    send_request(AdcW'(4095), TempW'(0));
    send_request(AdcW'(4095), TempW'(63));
    send_request(AdcW'(100), TempW'(30));

    // Equal calibration temperatures
    configure('0, CfgDataW'(CfgPointsTwo), CfgDataW'(3300), CfgDataW'(20),
              CfgDataW'(1000), CfgDataW'(20));
    send_request(AdcW'(1000), TempW'(20));

    // Rejected point counts
    configure('0, CfgDataW'(CfgPointsNone), CfgDataW'(3300), CfgDataW'(20),
              CfgDataW'(1000), CfgDataW'(10));
    send_request(AdcW'(1000), TempW'(10));
    configure('0, CfgDataW'(CfgPointsBad), CfgDataW'(3300), CfgDataW'(20),
              CfgDataW'(1000), CfgDataW'(10));
    send_request(AdcW'(1000), TempW'(10));

    // Full-scale single point; writes past the register list must be ignored
    configure('0, CfgDataW'(CfgPointsOne), CfgDataW'(3300), '0, '0, '0);
    write_reg(CfgIdxSpareLo, CfgDataW'(12'hFFF));
    write_reg(CfgIdxSpareHi, CfgDataW'(12'hFFF));
    send_request(AdcW'(4095), TempW'(0));
    send_request(AdcW'(4095), TempW'(40));

    // Two points whose line gives zero saturation
    configure('0, CfgDataW'(CfgPointsTwo), '0, CfgDataW'(10), '0, CfgDataW'(30));
    send_request(AdcW'(5), TempW'(5));

    // Random settings in batches, under three idle profiles
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 9 : (phase == 1) ? 53 : 0;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        random_calibration();
        batch = $urandom_range(30, 60);
        repeat (batch) send_random();
        sent += batch;
      end
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/doc_pkg.sv
hdl/doc_front.sv
hdl/doc_queue.sv
hdl/doc_back.sv
hdl/dissolved_oxygen_compensation.sv
sim/dissolved_oxygen_compensation_test.sv
